// File: rtl/core/cedit_pkg.sv
// Shared types and helpers for the case-folded edit distance chain.
package cedit_pkg;

    // Control part of one wavefront moving down the column chain.
    typedef struct packed {
        logic       valid;
        logic       last;
        logic [7:0] text;   // already case-folded
    } cedit_wave_t;

    // ASCII A-Z fold to a-z, everything else passes unchanged.
    function automatic logic [7:0] fold_byte(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b >= 8'h41 && b <= 8'h5A) begin
            r = b + 8'h20;
        end
        return r;
    endfunction

endpackage

// File: rtl/core/cedit_cfg.sv
// APB register file: pattern words and pattern length.
module cedit_cfg #(
    parameter int MAX_PATTERN = 32
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [5:0]                         paddr,
    input  logic [63:0]                        pwdata,
    output logic [63:0]                        prdata,
    output logic [255:0]                       pattern,
    output logic [$clog2(MAX_PATTERN+1)-1:0]   pat_len
);
    import cedit_pkg::*;

    localparam int NW = $clog2(MAX_PATTERN + 1);

    localparam logic [2:0] REG_PAT0 = 3'd0;
    localparam logic [2:0] REG_PAT1 = 3'd1;
    localparam logic [2:0] REG_PAT2 = 3'd2;
    localparam logic [2:0] REG_PAT3 = 3'd3;
    localparam logic [2:0] REG_LEN  = 3'd4;

    logic [3:0][63:0] pat_reg;
    logic [5:0]       len_reg;
    logic [2:0]       reg_idx;
    logic             wr_en;

    assign reg_idx = paddr[5:3];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_reg <= '0;
            len_reg <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_PAT0: pat_reg[0] <= pwdata;
                REG_PAT1: pat_reg[1] <= pwdata;
                REG_PAT2: pat_reg[2] <= pwdata;
                REG_PAT3: pat_reg[3] <= pwdata;
                REG_LEN:  len_reg    <= pwdata[5:0];
                default:  ;  // unmapped, ignored
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_PAT0: prdata = pat_reg[0];
            REG_PAT1: prdata = pat_reg[1];
            REG_PAT2: prdata = pat_reg[2];
            REG_PAT3: prdata = pat_reg[3];
            REG_LEN:  prdata = {58'd0, len_reg};
            default:  prdata = '0;
        endcase
    end

    assign pattern = pat_reg;
    // lengths past the chain depth read the last column
    assign pat_len = (len_reg > 6'(MAX_PATTERN)) ? NW'(MAX_PATTERN) : len_reg[NW-1:0];

endmodule

// File: rtl/core/cedit_head.sv
// Column 0 of the chain: row index counter and wave launch.
module cedit_head #(
    parameter int MAX_PATTERN = 32,
    parameter int DIST_WIDTH  = 10
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              advance,
    input  logic                              take_in,
    input  logic [7:0]                        in_byte,
    input  logic                              in_last,
    input  logic [$clog2(MAX_PATTERN+1)-1:0]  pat_len,
    output cedit_pkg::cedit_wave_t            wave_out,
    output logic [DIST_WIDTH-1:0]             new_out,
    output logic [DIST_WIDTH-1:0]             old_out,
    output logic [DIST_WIDTH-1:0]             res_out
);
    import cedit_pkg::*;

    localparam int DW = DIST_WIDTH;

    cedit_wave_t   wave_reg;
    logic [DW-1:0] row_index_reg;
    logic [DW-1:0] new_reg, old_reg, res_reg;
    logic [DW:0]   inc_sum;
    logic [DW-1:0] inc_sat;

    assign inc_sum = {1'b0, row_index_reg} + 1'b1;
    assign inc_sat = inc_sum[DW] ? '1 : inc_sum[DW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wave_reg      <= '0;
            row_index_reg <= '0;
        end else if (advance) begin
            wave_reg.valid <= take_in;
            wave_reg.last  <= in_last;
            wave_reg.text  <= fold_byte(in_byte);
            if (take_in) begin
                row_index_reg <= in_last ? '0 : inc_sat;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && take_in) begin
            new_reg <= inc_sat;
            old_reg <= row_index_reg;
            res_reg <= (pat_len == '0) ? inc_sat : '0;
        end
    end

    assign wave_out = wave_reg;
    assign new_out  = new_reg;
    assign old_out  = old_reg;
    assign res_out  = res_reg;

    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && take_in && in_last |=> row_index_reg == '0)
        else $error("row index not cleared after end of text");

    a_index_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && take_in && !in_last && row_index_reg != '1
        |=> row_index_reg == $past(row_index_reg) + 1'b1)
        else $error("row index did not step by one");

endmodule

// File: rtl/core/cedit_cell.sv
// One pattern column of the chain: holds distance_row[J], updates it per wave.
module cedit_cell #(
    parameter int MAX_PATTERN = 32,
    parameter int DIST_WIDTH  = 10,
    parameter int J           = 1
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              advance,
    input  logic [7:0]                        pat_byte,
    input  logic [$clog2(MAX_PATTERN+1)-1:0]  pat_len,
    input  cedit_pkg::cedit_wave_t            wave_in,
    input  logic [DIST_WIDTH-1:0]             new_in,
    input  logic [DIST_WIDTH-1:0]             old_in,
    input  logic [DIST_WIDTH-1:0]             res_in,
    output cedit_pkg::cedit_wave_t            wave_out,
    output logic [DIST_WIDTH-1:0]             new_out,
    output logic [DIST_WIDTH-1:0]             old_out,
    output logic [DIST_WIDTH-1:0]             res_out
);
    import cedit_pkg::*;

    localparam int DW = DIST_WIDTH;
    localparam int NW = $clog2(MAX_PATTERN + 1);

    cedit_wave_t   wave_reg;
    logic [DW-1:0] dist_reg;
    logic [DW-1:0] new_reg, old_reg, res_reg;

    logic          mismatch;
    logic [DW:0]   up_sum, left_sum, diag_sum;
    logic [DW-1:0] up_sat, left_sat, diag_sat, best_ul, best;
    logic          do_step;

    assign do_step  = advance && wave_in.valid;
    assign mismatch = (fold_byte(pat_byte) != wave_in.text);

    // deletion from above, insertion from the left, substitution on the diagonal
    assign up_sum   = {1'b0, dist_reg} + 1'b1;
    assign left_sum = {1'b0, new_in} + 1'b1;
    assign diag_sum = {1'b0, old_in} + {{DW{1'b0}}, mismatch};
    assign up_sat   = up_sum[DW]   ? '1 : up_sum[DW-1:0];
    assign left_sat = left_sum[DW] ? '1 : left_sum[DW-1:0];
    assign diag_sat = diag_sum[DW] ? '1 : diag_sum[DW-1:0];
    assign best_ul  = (left_sat < up_sat) ? left_sat : up_sat;
    assign best     = (diag_sat < best_ul) ? diag_sat : best_ul;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wave_reg <= '0;
            dist_reg <= DW'(J);
        end else if (advance) begin
            wave_reg <= wave_in;
            if (wave_in.valid) begin
                dist_reg <= wave_in.last ? DW'(J) : best;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_step) begin
            new_reg <= best;
            old_reg <= dist_reg;
            res_reg <= (pat_len == NW'(J)) ? best : res_in;
        end
    end

    assign wave_out = wave_reg;
    assign new_out  = new_reg;
    assign old_out  = old_reg;
    assign res_out  = res_reg;

    a_hold_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !do_step |=> $stable(dist_reg))
        else $error("column changed without a wave");

    a_restore: assert property (@(posedge aclk) disable iff (!aresetn)
        do_step && wave_in.last |=> dist_reg == DW'(J))
        else $error("column not restored after end of text");

endmodule

// File: rtl/core/case_folded_edit_distance.sv
// A result is valid once its text byte has passed the head register and every column register.
// Throughput: one text byte per cycle when not stalled; each byte walks the chain one column a cycle.
// Backpressure: a stalled result freezes the whole chain, so s_tready follows m_tready.
// Reset: aresetn is synchronous, active low; the row returns to 0..MAX_PATTERN,
// the row index to 0 and all pattern registers to 0.
module case_folded_edit_distance #(
    parameter int MAX_PATTERN = 32,
    parameter int DIST_WIDTH  = 10
) (
    input  logic        aclk,
    input  logic        aresetn,
    // text input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] text_byte
    input  logic        s_tlast,   // end_of_text
    // distance output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [9:0] distance, [15:10] zero
    output logic        m_tlast,   // final_res
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import cedit_pkg::*;

    localparam int DW = DIST_WIDTH;
    localparam int NW = $clog2(MAX_PATTERN + 1);

    logic [255:0]  pattern;
    logic [NW-1:0] pat_len;
    logic          advance;
    logic          take_in;

    // Stage k of these arrays is the registered output of column k.
    cedit_wave_t   wave   [0:MAX_PATTERN];
    logic [DW-1:0] new_d  [0:MAX_PATTERN];
    logic [DW-1:0] old_d  [0:MAX_PATTERN];
    logic [DW-1:0] res_d  [0:MAX_PATTERN];

    logic [DW+9:0] dist_ext;

    assign pready = 1'b1;

    cedit_cfg #(
        .MAX_PATTERN(MAX_PATTERN)
    ) u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pattern (pattern),
        .pat_len (pat_len)
    );

    // The last column's registers double as the output register; the chain moves
    // only when that register is empty or being drained.
    assign advance  = !m_tvalid || m_tready;
    assign s_tready = advance;
    assign take_in  = s_tvalid && advance;

    cedit_head #(
        .MAX_PATTERN(MAX_PATTERN),
        .DIST_WIDTH (DIST_WIDTH)
    ) u_head (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (advance),
        .take_in  (take_in),
        .in_byte  (s_tdata),
        .in_last  (s_tlast),
        .pat_len  (pat_len),
        .wave_out (wave[0]),
        .new_out  (new_d[0]),
        .old_out  (old_d[0]),
        .res_out  (res_d[0])
    );

    // Column j compares against pattern byte j-1. Each wave carries the new and
    // old value of the column to its left (left and diagonal terms) and picks up
    // the result when it passes the column selected by the pattern length.
    for (genvar j = 1; j <= MAX_PATTERN; j++) begin : g_col
        cedit_cell #(
            .MAX_PATTERN(MAX_PATTERN),
            .DIST_WIDTH (DIST_WIDTH),
            .J          (j)
        ) u_col (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .advance  (advance),
            .pat_byte (pattern[8*(j-1) +: 8]),
            .pat_len  (pat_len),
            .wave_in  (wave[j-1]),
            .new_in   (new_d[j-1]),
            .old_in   (old_d[j-1]),
            .res_in   (res_d[j-1]),
            .wave_out (wave[j]),
            .new_out  (new_d[j]),
            .old_out  (old_d[j]),
            .res_out  (res_d[j])
        );
    end

    // distance field is the low 10 bits of the saturated value
    assign dist_ext = {10'd0, res_d[MAX_PATTERN]};

    assign m_tvalid = wave[MAX_PATTERN].valid;
    assign m_tlast  = wave[MAX_PATTERN].last;
    assign m_tdata  = {6'd0, dist_ext[9:0]};

    a_ready_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while chain is stalled");

endmodule
